// File: rtl/ipv4v_pkg.sv
// Shared types and constants for the IPv4 receive header validator.
package ipv4v_pkg;

	localparam int COUNT_WIDTH = 32;

	localparam logic [15:0] MIN_HEADER_BYTES = 16'd20;
	localparam logic [3:0]  IP_VERSION       = 4'd4;
	localparam logic [3:0]  IHL_MIN          = 4'd5;
	localparam logic [15:0] FRAG_BITS        = 16'h3fff;
	localparam logic [7:0]  PROTO_ICMP       = 8'd1;
	localparam logic [7:0]  PROTO_UDP        = 8'd17;
	localparam logic [15:0] BYTE_INDEX_MAX   = 16'hffff;
	localparam logic [15:0] CHECKSUM_GOOD    = 16'hffff;

	typedef enum logic [2:0] {
		VERDICT_OK        = 3'd0,
		VERDICT_SHORT     = 3'd1,
		VERDICT_VERSION   = 3'd2,
		VERDICT_LENGTH    = 3'd3,
		VERDICT_FRAGMENT  = 3'd4,
		VERDICT_CHECKSUM  = 3'd5,
		VERDICT_NOT_LOCAL = 3'd6
	} verdict_t;

	typedef enum logic [1:0] {
		PCLASS_ICMP  = 2'd0,
		PCLASS_UDP   = 2'd1,
		PCLASS_OTHER = 2'd2
	} pclass_t;

	typedef struct packed {
		logic [15:0] byte_index;
		logic [7:0]  version_ihl;
		logic [15:0] total_length;
		logic [15:0] fragment_field;
		logic [7:0]  protocol_number;
		logic [31:0] source_word;
		logic [31:0] destination_word;
		logic [15:0] checksum_sum;
	} hdr_t;

	typedef struct packed {
		verdict_t    verdict;
		pclass_t     protocol_class;
		logic [5:0]  header_length;
		logic [15:0] payload_length;
	} decision_t;

endpackage

// File: rtl/ipv4v_if.sv
// Stream interfaces for received bytes and per-packet results.
interface ipv4v_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       frame_end;

	modport source (output valid, data_byte, frame_end, input ready);
	modport sink (input valid, data_byte, frame_end, output ready);
endinterface

interface ipv4v_res_if;
	logic        valid;
	logic        ready;
	logic [2:0]  verdict;
	logic [1:0]  protocol_class;
	logic [31:0] source_address;
	logic [5:0]  header_length;
	logic [15:0] payload_length;
	logic [31:0] accepted_count;
	logic [31:0] dropped_count;

	modport source (output valid, verdict, protocol_class, source_address, header_length,
		payload_length, accepted_count, dropped_count, input ready);
	modport sink (input valid, verdict, protocol_class, source_address, header_length,
		payload_length, accepted_count, dropped_count, output ready);
endinterface

// File: rtl/ipv4_rx_header_validator_top.sv
// IPv4 receive header validator: input register, header capture, verdict and result register.
// A frame's last byte passes through the input register; its result is then loaded into the result register.
// Throughput: one byte per cycle; the input stalls only while a finished result is held and not yet
// taken, and the next byte in the input register also ends a frame.
// Reset: arst_n clears the packet state, counters, local_address and both valid flags.
module ipv4_rx_header_validator_top
	import ipv4v_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	ipv4v_in_if.sink     rx,
	ipv4v_res_if.source  res,
	input  logic         cfg_wr_en,
	input  logic [31:0]  cfg_wr_data
);

	logic                   valid_s1;
	logic [7:0]             byte_s1;
	logic                   end_s1;
	logic                   advance;
	logic                   step;
	logic                   load;
	logic [31:0]            local_address_q;
	logic [COUNT_WIDTH-1:0] ok_count_q;
	logic [COUNT_WIDTH-1:0] drop_count_q;
	logic [COUNT_WIDTH-1:0] ok_count_d;
	logic [COUNT_WIDTH-1:0] drop_count_d;
	hdr_t                   hdr;
	decision_t              dec;

	logic        valid_s2;
	verdict_t    verdict_s2;
	pclass_t     pclass_s2;
	logic [31:0] source_s2;
	logic [5:0]  hlen_s2;
	logic [15:0] plen_s2;
	logic [31:0] ok_s2;
	logic [31:0] drop_s2;

	assign advance  = !end_s1 || !valid_s2 || res.ready;
	assign step     = valid_s1 && advance;
	assign load     = step && end_s1;
	assign rx.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_address_q <= '0;
		end else if (cfg_wr_en) begin
			local_address_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.data_byte;
			end_s1  <= rx.frame_end;
		end
	end

	ipv4v_hdr_capture u_capture (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.data_byte (byte_s1),
		.frame_end (end_s1),
		.hdr       (hdr)
	);

	ipv4v_verdict u_verdict (
		.hdr           (hdr),
		.local_address (local_address_q),
		.dec           (dec)
	);

	always_comb begin
		ok_count_d   = ok_count_q;
		drop_count_d = drop_count_q;
		if (dec.verdict == VERDICT_OK) begin
			ok_count_d = ok_count_q + COUNT_WIDTH'(1);
		end else begin
			drop_count_d = drop_count_q + COUNT_WIDTH'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ok_count_q   <= '0;
			drop_count_q <= '0;
			valid_s2     <= 1'b0;
		end else begin
			if (load) begin
				ok_count_q   <= ok_count_d;
				drop_count_q <= drop_count_d;
				valid_s2     <= 1'b1;
			end else if (res.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			verdict_s2 <= dec.verdict;
			pclass_s2  <= dec.protocol_class;
			source_s2  <= hdr.source_word;
			hlen_s2    <= dec.header_length;
			plen_s2    <= dec.payload_length;
			ok_s2      <= 32'(ok_count_d);
			drop_s2    <= 32'(drop_count_d);
		end
	end

	assign res.valid          = valid_s2;
	assign res.verdict        = verdict_s2;
	assign res.protocol_class = pclass_s2;
	assign res.source_address = source_s2;
	assign res.header_length  = hlen_s2;
	assign res.payload_length = plen_s2;
	assign res.accepted_count = ok_s2;
	assign res.dropped_count  = drop_s2;

endmodule

// File: rtl/ipv4v_hdr_capture.sv
// Per-packet header field capture, byte count and running header checksum.
module ipv4v_hdr_capture
	import ipv4v_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] data_byte,
	input  logic       frame_end,
	output hdr_t       hdr
);

	hdr_t       hdr_q;
	logic [7:0] high_byte_q;
	logic [7:0] high_byte_d;
	logic [5:0] hlen;
	logic [16:0] sum_wide;
	logic [15:0] p;

	always_comb begin
		p           = hdr_q.byte_index;
		hdr         = hdr_q;
		high_byte_d = high_byte_q;
		sum_wide    = '0;
		if (p == 16'd0) begin
			hdr.version_ihl = data_byte;
		end else if (p == 16'd2 || p == 16'd3) begin
			hdr.total_length = {hdr_q.total_length[7:0], data_byte};
		end else if (p == 16'd6 || p == 16'd7) begin
			hdr.fragment_field = {hdr_q.fragment_field[7:0], data_byte};
		end else if (p == 16'd9) begin
			hdr.protocol_number = data_byte;
		end else if (p >= 16'd12 && p <= 16'd15) begin
			hdr.source_word = {hdr_q.source_word[23:0], data_byte};
		end else if (p >= 16'd16 && p <= 16'd19) begin
			hdr.destination_word = {hdr_q.destination_word[23:0], data_byte};
		end
		hlen = {hdr.version_ihl[3:0], 2'b00};
		if (p < {10'd0, hlen}) begin
			if (!p[0]) begin
				high_byte_d = data_byte;
			end else begin
				sum_wide = {1'b0, hdr_q.checksum_sum} + {1'b0, high_byte_q, data_byte};
				if (sum_wide[16]) begin
					hdr.checksum_sum = sum_wide[15:0] + 16'd1;
				end else begin
					hdr.checksum_sum = sum_wide[15:0];
				end
			end
		end
		hdr.byte_index = (p < BYTE_INDEX_MAX) ? p + 16'd1 : BYTE_INDEX_MAX;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q       <= '0;
			high_byte_q <= '0;
		end else if (step) begin
			if (frame_end) begin
				hdr_q       <= '0;
				high_byte_q <= '0;
			end else begin
				hdr_q       <= hdr;
				high_byte_q <= high_byte_d;
			end
		end
	end

endmodule

// File: rtl/ipv4v_verdict.sv
// Packet verdict, protocol class and length decode from the captured header.
module ipv4v_verdict
	import ipv4v_pkg::*;
(
	input  hdr_t        hdr,
	input  logic [31:0] local_address,
	output decision_t   dec
);

	logic [15:0] hlen;
	logic [15:0] len;

	always_comb begin
		len  = hdr.byte_index;
		hlen = {10'd0, hdr.version_ihl[3:0], 2'b00};
		dec.header_length = hlen[5:0];

		priority if (len < MIN_HEADER_BYTES) begin
			dec.verdict = VERDICT_SHORT;
		end else if (hdr.version_ihl[7:4] != IP_VERSION || hdr.version_ihl[3:0] < IHL_MIN) begin
			dec.verdict = VERDICT_VERSION;
		end else if (hlen > len || hdr.total_length < hlen || hdr.total_length > len) begin
			dec.verdict = VERDICT_LENGTH;
		end else if ((hdr.fragment_field & FRAG_BITS) != 16'd0) begin
			dec.verdict = VERDICT_FRAGMENT;
		end else if (hdr.checksum_sum != CHECKSUM_GOOD) begin
			dec.verdict = VERDICT_CHECKSUM;
		end else if (hdr.destination_word != local_address) begin
			dec.verdict = VERDICT_NOT_LOCAL;
		end else begin
			dec.verdict = VERDICT_OK;
		end

		dec.payload_length = (dec.verdict == VERDICT_OK) ? hdr.total_length - hlen : 16'd0;

		priority if (hdr.protocol_number == PROTO_ICMP) begin
			dec.protocol_class = PCLASS_ICMP;
		end else if (hdr.protocol_number == PROTO_UDP) begin
			dec.protocol_class = PCLASS_UDP;
		end else begin
			dec.protocol_class = PCLASS_OTHER;
		end
	end

endmodule

// File: bench/tb_ipv4_rx_header_validator_top.sv
// Testbench for the IPv4 receive header validator: byte stream stimulus with a verdict scoreboard.
module tb_ipv4_rx_header_validator_top;
	import ipv4v_pkg::*;

	localparam int QUIET_LIMIT = 4000;

	typedef struct {
		verdict_t    verdict;
		pclass_t     pclass;
		logic [31:0] src_addr;
		logic [5:0]  hdr_len;
		logic [15:0] pay_len;
		logic [31:0] ok_total;
		logic [31:0] drop_total;
	} ipv4_verdict_t;

	typedef enum {SINK_OPEN, SINK_COIN, SINK_TIGHT, SINK_BEAT} sink_mode_t;

	class header_verdict_tracker;
		logic [31:0]   local_addr;
		logic [15:0]   pos;
		logic [7:0]    ver_ihl;
		logic [15:0]   tot_len;
		logic [15:0]   frag_word;
		logic [7:0]    proto;
		logic [31:0]   src_word;
		logic [31:0]   dst_word;
		logic [16:0]   csum;
		logic [7:0]    hi_byte;
		logic [31:0]   ok_total;
		logic [31:0]   drop_total;
		ipv4_verdict_t verdicts_due[$];
		int            faults;

		function new();
			local_addr = '0;
			ok_total = '0;
			drop_total = '0;
			faults = 0;
			clear_packet();
		endfunction

		function void clear_packet();
			pos = '0;
			ver_ihl = '0;
			tot_len = '0;
			frag_word = '0;
			proto = '0;
			src_word = '0;
			dst_word = '0;
			csum = '0;
			hi_byte = '0;
		endfunction

		function void note_byte(logic [7:0] b, logic last);
			logic [15:0]   p;
			logic [5:0]    hlen;
			logic [16:0]   sum;
			ipv4_verdict_t v;
			p = pos;
			if (p == 0) ver_ihl = b;
			else if (p == 2 || p == 3) tot_len = {tot_len[7:0], b};
			else if (p == 6 || p == 7) frag_word = {frag_word[7:0], b};
			else if (p == 9) proto = b;
			else if (p >= 12 && p <= 15) src_word = {src_word[23:0], b};
			else if (p >= 16 && p <= 19) dst_word = {dst_word[23:0], b};
			hlen = {ver_ihl[3:0], 2'b00};
			if (p < 16'(hlen)) begin
				if (!p[0]) begin
					hi_byte = b;
				end else begin
					sum = csum + {hi_byte, b};
					csum = (sum > 17'h0ffff) ? {1'b0, sum[15:0]} + 17'd1 : sum;
				end
			end
			if (p != BYTE_INDEX_MAX) pos = p + 16'd1;
			if (!last) return;
			v.hdr_len = hlen;
			v.src_addr = src_word;
			v.pay_len = '0;
			if (pos < MIN_HEADER_BYTES)
				v.verdict = VERDICT_SHORT;
			else if (ver_ihl[7:4] != IP_VERSION || ver_ihl[3:0] < IHL_MIN)
				v.verdict = VERDICT_VERSION;
			else if (16'(hlen) > pos || tot_len < 16'(hlen) || tot_len > pos)
				v.verdict = VERDICT_LENGTH;
			else if ((frag_word & FRAG_BITS) != 16'd0)
				v.verdict = VERDICT_FRAGMENT;
			else if (csum != {1'b0, CHECKSUM_GOOD})
				v.verdict = VERDICT_CHECKSUM;
			else if (dst_word != local_addr)
				v.verdict = VERDICT_NOT_LOCAL;
			else
				v.verdict = VERDICT_OK;
			if (v.verdict == VERDICT_OK) begin
				ok_total = ok_total + 32'd1;
				v.pay_len = tot_len - 16'(hlen);
			end else begin
				drop_total = drop_total + 32'd1;
			end
			if (proto == PROTO_ICMP) v.pclass = PCLASS_ICMP;
			else if (proto == PROTO_UDP) v.pclass = PCLASS_UDP;
			else v.pclass = PCLASS_OTHER;
			v.ok_total = ok_total;
			v.drop_total = drop_total;
			verdicts_due.push_back(v);
			clear_packet();
		endfunction

		function void check_verdict(ipv4_verdict_t got);
			ipv4_verdict_t want;
			logic [31:0]   want_f[7];
			logic [31:0]   got_f[7];
			string         tag[7];
			if (verdicts_due.size() == 0) begin
				$display("%0t: result with nothing pending, verdict %0d", $time, got.verdict);
				faults++;
				return;
			end
			want = verdicts_due.pop_front();
			tag = '{"verdict", "protocol_class", "source_address", "header_length",
				"payload_length", "accepted_count", "dropped_count"};
			want_f = '{want.verdict, want.pclass, want.src_addr, want.hdr_len,
				want.pay_len, want.ok_total, want.drop_total};
			got_f = '{got.verdict, got.pclass, got.src_addr, got.hdr_len,
				got.pay_len, got.ok_total, got.drop_total};
			for (int i = 0; i < 7; i++) begin
				if (want_f[i] !== got_f[i]) begin
					$display("%0t: %s expected %0h actual %0h", $time, tag[i], want_f[i],
						got_f[i]);
					faults++;
				end
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [31:0] cfg_wr_data;

	ipv4v_in_if  rx_bus();
	ipv4v_res_if res_bus();

	header_verdict_tracker tracker;
	logic [7:0]  pkt[$];
	int          burst_left = 0;
	int          bytes_sent = 0;
	int          mode_left = 0;
	int          quiet_cycles = 0;
	sink_mode_t  sink_mode = SINK_OPEN;

	ipv4_rx_header_validator_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx_bus),
		.res(res_bus),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	initial clk = 1'b0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(negedge clk) begin
		if (mode_left == 0) begin
			mode_left = $urandom_range(250, 20);
			sink_mode = sink_mode_t'($urandom_range(3, 0));
		end
		mode_left--;
		case (sink_mode)
			SINK_OPEN: res_bus.ready <= 1'b1;
			SINK_COIN: res_bus.ready <= 1'($urandom_range(1, 0));
			SINK_TIGHT: res_bus.ready <= ($urandom_range(7, 0) == 0);
			default: res_bus.ready <= (mode_left % 5 != 0);
		endcase
	end

	always @(posedge clk) begin : result_check
		ipv4_verdict_t got;
		if (arst_n && res_bus.valid && res_bus.ready) begin
			got.verdict = verdict_t'(res_bus.verdict);
			got.pclass = pclass_t'(res_bus.protocol_class);
			got.src_addr = res_bus.source_address;
			got.hdr_len = res_bus.header_length;
			got.pay_len = res_bus.payload_length;
			got.ok_total = res_bus.accepted_count;
			got.drop_total = res_bus.dropped_count;
			tracker.check_verdict(got);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (rx_bus.valid && rx_bus.ready) || (res_bus.valid && res_bus.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("tb_ipv4_rx_header_validator_top: errors");
				$finish;
			end
		end
	end

	task automatic push_byte(input logic [7:0] b, input logic last);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(4, 0) == 0) ? $urandom_range(300, 60)
				: $urandom_range(12, 1);
			gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
			if (gap > 0) begin
				rx_bus.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		rx_bus.valid <= 1'b1;
		rx_bus.data_byte <= b;
		rx_bus.frame_end <= last;
		do @(posedge clk); while (!rx_bus.ready);
		tracker.note_byte(b, last);
		burst_left--;
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_packet();
		for (int i = 0; i < pkt.size(); i++)
			push_byte(pkt[i], i == pkt.size() - 1);
	endtask

	// drain every pending verdict before touching the address register
	task automatic settle();
		rx_bus.valid <= 1'b0;
		while (tracker.verdicts_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_local(input logic [31:0] addr);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= addr;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		tracker.local_addr = addr;
	endtask

	task automatic fill_random(input int n);
		pkt.delete();
		repeat (n) pkt.push_back(8'($urandom));
	endtask

	task automatic seal_checksum(input int hl);
		int          s;
		logic [15:0] c;
		pkt[10] = 8'd0;
		pkt[11] = 8'd0;
		s = 0;
		for (int i = 0; i < hl; i += 2)
			s += {pkt[i], pkt[i + 1]};
		while (s > 32'h0ffff)
			s = (s & 32'h0ffff) + (s >> 16);
		c = ~s[15:0];
		pkt[10] = c[15:8];
		pkt[11] = c[7:0];
	endtask

	task automatic set_total(input int hl, input logic [15:0] tot);
		pkt[2] = tot[15:8];
		pkt[3] = tot[7:0];
		seal_checksum(hl);
	endtask

	task automatic build_packet(input logic [3:0] ihl, input int pay_n, input logic [7:0] proto_b,
		input logic [15:0] frag, input logic [31:0] src, input logic [31:0] dst,
		input int pad_n);
		int          hl;
		logic [15:0] tot;
		hl = ihl * 4;
		tot = 16'(hl + pay_n);
		pkt.delete();
		pkt.push_back({IP_VERSION, ihl});
		pkt.push_back(8'($urandom));
		pkt.push_back(tot[15:8]);
		pkt.push_back(tot[7:0]);
		pkt.push_back(8'($urandom));
		pkt.push_back(8'($urandom));
		pkt.push_back(frag[15:8]);
		pkt.push_back(frag[7:0]);
		pkt.push_back(8'($urandom));
		pkt.push_back(proto_b);
		pkt.push_back(8'd0);
		pkt.push_back(8'd0);
		for (int k = 3; k >= 0; k--) pkt.push_back(8'(src >> (8 * k)));
		for (int k = 3; k >= 0; k--) pkt.push_back(8'(dst >> (8 * k)));
		repeat (hl - 20) pkt.push_back(8'($urandom));
		seal_checksum(hl);
		repeat (pay_n + pad_n) pkt.push_back(8'($urandom));
	endtask

	task automatic random_frame();
		int          roll;
		int          hl;
		int          n;
		logic [3:0]  ihl;
		logic [7:0]  proto_b;
		logic [31:0] flip;
		roll = $urandom_range(99, 0);
		ihl = ($urandom_range(4, 0) != 0) ? IHL_MIN : 4'($urandom_range(15, 6));
		hl = ihl * 4;
		case ($urandom_range(2, 0))
			0: proto_b = PROTO_ICMP;
			1: proto_b = PROTO_UDP;
			default: proto_b = 8'($urandom);
		endcase
		build_packet(ihl,
			($urandom_range(9, 0) == 0) ? $urandom_range(64, 11) : $urandom_range(10, 0),
			proto_b, {2'($urandom), 14'd0}, $urandom, tracker.local_addr,
			(roll >= 45 && roll < 52) ? $urandom_range(8, 1) : 0);
		if (roll < 52) begin
			// well-formed, possibly with trailing pad
		end else if (roll < 57) begin
			n = $urandom_range(14, 0);
			pkt[0] = {4'((n >= IP_VERSION) ? n + 1 : n), pkt[0][3:0]};
		end else if (roll < 62) begin
			pkt[0] = {pkt[0][7:4], 4'($urandom_range(4, 0))};
		end else if (roll < 67) begin
			set_total(hl, 16'(pkt.size() + $urandom_range(50, 1)));
		end else if (roll < 71) begin
			set_total(hl, 16'($urandom_range(hl - 1, 0)));
		end else if (roll < 75) begin
			if (pkt.size() > 20) begin
				n = $urandom_range(pkt.size() - 1, 20);
				while (pkt.size() > n) void'(pkt.pop_back());
			end
		end else if (roll < 80) begin
			n = $urandom_range(16'h3fff, 1);
			pkt[6] = {pkt[6][7:6], 6'(n >> 8)};
			pkt[7] = 8'(n);
			seal_checksum(hl);
		end else if (roll < 86) begin
			n = $urandom_range(15, 8);
			pkt[n] = pkt[n] ^ 8'(1 << $urandom_range(7, 0));
		end else if (roll < 91) begin
			flip = $urandom;
			if (flip == 32'd0) flip = 32'd1;
			for (int k = 0; k < 4; k++) pkt[16 + k] = pkt[16 + k] ^ 8'(flip >> (24 - 8 * k));
			seal_checksum(hl);
		end else if (roll < 95) begin
			fill_random($urandom_range(19, 1));
			if ($urandom_range(1, 0) != 0) pkt[0] = {IP_VERSION, IHL_MIN};
		end else begin
			fill_random($urandom_range(48, 1));
		end
		send_packet();
	endtask

	task automatic run_phase(input logic [31:0] addr, input int amount);
		int stop;
		settle();
		write_local(addr);
		stop = bytes_sent + amount;
		while (bytes_sent < stop) random_frame();
	endtask

	initial begin
		tracker = new();
		arst_n = 1'b0;
		rx_bus.valid = 1'b0;
		rx_bus.data_byte = 8'd0;
		rx_bus.frame_end = 1'b0;
		res_bus.ready = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = 32'd0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		// single byte frames, then a short header, an all-zero header and a well-formed ICMP packet
		repeat (3) begin
			pkt = '{8'hff};
			send_packet();
		end
		fill_random(19);
		send_packet();
		pkt.delete();
		repeat (20) pkt.push_back(8'd0);
		send_packet();
		build_packet(IHL_MIN, 0, PROTO_ICMP, 16'h0000, 32'hffffffff, tracker.local_addr, 0);
		send_packet();

		settle();
		write_local(32'hc0a80a01);
		build_packet(4'd15, 4, PROTO_UDP, 16'h4000, 32'h00000000, tracker.local_addr, 0);
		send_packet();
		build_packet(IHL_MIN, 6, 8'hff, 16'h8000, $urandom, tracker.local_addr, 3);
		send_packet();
		build_packet(IHL_MIN, 2, 8'h06, 16'h2000, $urandom, tracker.local_addr, 0);
		send_packet();
		build_packet(IHL_MIN, 2, PROTO_UDP, 16'h1fff, $urandom, tracker.local_addr, 0);
		send_packet();
		build_packet(IHL_MIN, 3, PROTO_ICMP, 16'h0000, $urandom, tracker.local_addr, 0);
		pkt[12] = pkt[12] ^ 8'h01;
		send_packet();
		build_packet(IHL_MIN, 3, PROTO_UDP, 16'h0000, $urandom, ~tracker.local_addr, 0);
		send_packet();
		build_packet(IHL_MIN, 1, PROTO_UDP, 16'h0000, $urandom, tracker.local_addr, 0);
		pkt[0] = {4'd6, IHL_MIN};
		send_packet();
		build_packet(IHL_MIN, 1, PROTO_UDP, 16'h0000, $urandom, tracker.local_addr, 0);
		pkt[0] = {IP_VERSION, 4'd4};
		send_packet();
		build_packet(4'd6, 0, PROTO_ICMP, 16'h0000, $urandom, tracker.local_addr, 0);
		while (pkt.size() > 22) void'(pkt.pop_back());
		send_packet();
		build_packet(IHL_MIN, 4, PROTO_ICMP, 16'h0000, $urandom, tracker.local_addr, 0);
		set_total(20, 16'(pkt.size() + 1));
		send_packet();
		build_packet(IHL_MIN, 4, PROTO_ICMP, 16'h0000, $urandom, tracker.local_addr, 0);
		set_total(20, 16'd19);
		send_packet();

		run_phase(32'hffffffff, 400);
		run_phase($urandom, 400);
		run_phase(32'h00000000, 400);
		settle();

		if (tracker.faults == 0)
			$display("tb_ipv4_rx_header_validator_top: clean");
		else
			$display("tb_ipv4_rx_header_validator_top: errors");
		$finish;
	end

endmodule
